>>> rtl/bmp_pkg.sv
`timescale 1ns / 1ps
// bmp_pkg: constants and shared types for the binomial mod prime unit
// no dependencies; used by every other file of the block
package bmp_pkg;

  localparam int N_W = 10;
  localparam int R_W = 30;
  localparam int N_MAX = (1 << N_W) - 1;

  localparam logic [R_W-1:0] PRIME = 30'd1000000007;
  localparam logic [R_W-1:0] FERMAT_EXP = PRIME - 30'd2;

  // barrett reduction constant floor(2^60 / p)
  localparam logic [63:0] BARRETT_WIDE = (64'd1 << 60) / 64'(PRIME);
  localparam logic [30:0] BARRETT_M = BARRETT_WIDE[30:0];

  localparam logic [31:0] PRIME_X1 = 32'(PRIME);
  localparam logic [31:0] PRIME_X2 = 32'(PRIME) << 1;

  // pipeline depth of the modular multiplier
  localparam int MUL_LAT = 4;

  typedef struct packed {
    logic           fact_we;
    logic           ifact_we;
    logic [N_W-1:0] addr;
    logic [R_W-1:0] data;
  } bmp_wr_t;

endpackage

>>> rtl/bmp_query_if.sv
`timescale 1ns / 1ps
// bmp_query_if: query channel carrying n and k
// depends on bmp_pkg
interface bmp_query_if import bmp_pkg::*; ();
  logic           valid;
  logic           ready;
  logic [N_W-1:0] n_value;
  logic [N_W-1:0] k_value;

  modport source(output valid, n_value, k_value, input ready);
  modport sink(input valid, n_value, k_value, output ready);
endinterface

>>> rtl/bmp_result_if.sv
`timescale 1ns / 1ps
// bmp_result_if: result channel carrying C(n,k) mod p
// depends on bmp_pkg
interface bmp_result_if import bmp_pkg::*; ();
  logic           valid;
  logic           ready;
  logic [R_W-1:0] binom_mod;

  modport source(output valid, binom_mod, input ready);
  modport sink(input valid, binom_mod, output ready);
endinterface

>>> rtl/bmp_modmul.sv
`timescale 1ns / 1ps
// bmp_modmul: pipelined a*b mod p with barrett reduction, four stages
// depends on bmp_pkg
module bmp_modmul import bmp_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_valid,
  input  logic [R_W-1:0] a,
  input  logic [R_W-1:0] b,
  output logic           out_valid,
  output logic [R_W-1:0] result
);

  logic [MUL_LAT-1:0] v_r;
  logic [59:0]        x_r;
  logic [61:0]        t_r;
  logic [31:0]        xl_r;
  logic [31:0]        r_r;
  logic [R_W-1:0]     res_r;
  logic [30:0]        q;
  logic [31:0]        qp;
  logic [31:0]        r_fix;

  assign q  = t_r[61:31];
  assign qp = 32'(q) * PRIME_X1;

  // remainder estimate is below 3p
  always_comb begin
    if (r_r >= PRIME_X2) begin
      r_fix = r_r - PRIME_X2;
    end else if (r_r >= PRIME_X1) begin
      r_fix = r_r - PRIME_X1;
    end else begin
      r_fix = r_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[MUL_LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r   <= 60'(a) * 60'(b);
      t_r   <= 62'(x_r[59:29]) * 62'(BARRETT_M);
      xl_r  <= x_r[31:0];
      r_r   <= xl_r - qp;
      res_r <= r_fix[R_W-1:0];
    end
  end

  assign out_valid = v_r[MUL_LAT-1];
  assign result    = res_r;

endmodule

>>> rtl/bmp_init.sv
`timescale 1ns / 1ps
// bmp_init: table fill sequencer run after reset (factorials forward,
// fermat inverse of the last factorial, inverse factorials backward)
// depends on bmp_pkg and bmp_modmul
module bmp_init import bmp_pkg::*; #(
  parameter int unsigned LIM = 1023
) (
  input  logic    clk,
  input  logic    rst_n,
  output bmp_wr_t wr,
  output logic    done
);

  localparam logic [1:0] PH_FACT  = 2'd0;
  localparam logic [1:0] PH_POW   = 2'd1;
  localparam logic [1:0] PH_IFACT = 2'd2;
  localparam logic [1:0] PH_DONE  = 2'd3;

  localparam logic [N_W-1:0] LAST = N_W'(LIM);

  logic [1:0]     phase_r;
  logic           busy_r;
  logic           sq_done_r;
  logic [4:0]     bit_r;
  logic [N_W-1:0] idx_r;
  logic [R_W-1:0] acc_r;
  logic [R_W-1:0] base_r;
  logic           mul_v_r;
  logic [R_W-1:0] mul_a_r;
  logic [R_W-1:0] mul_b_r;
  bmp_wr_t        wr_r;
  logic           res_v;
  logic [R_W-1:0] res;
  logic           mul_go;
  logic           pow_last;
  logic           fact_wr;
  logic           ifact_wr;

  bmp_modmul u_mul (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (1'b1),
    .in_valid (mul_v_r),
    .a        (mul_a_r),
    .b        (mul_b_r),
    .out_valid(res_v),
    .result   (res)
  );

  assign mul_go   = !busy_r && ((phase_r == PH_FACT) || (phase_r == PH_POW) ||
                    ((phase_r == PH_IFACT) && (idx_r != '0)));
  // last step of the exponentiation writes the top inverse factorial
  assign pow_last = (phase_r == PH_POW) && busy_r && res_v &&
                    (sq_done_r || !FERMAT_EXP[bit_r]) && (bit_r == 5'd0);
  assign fact_wr  = (phase_r == PH_FACT) && busy_r && res_v;
  assign ifact_wr = pow_last || ((phase_r == PH_IFACT) && busy_r && res_v);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_FACT;
      busy_r    <= 1'b0;
      sq_done_r <= 1'b0;
      bit_r     <= 5'd29;
      idx_r     <= N_W'(1);
      acc_r     <= R_W'(1);
      mul_v_r   <= 1'b0;
      // entry zero of the factorial table is one
      wr_r      <= '{fact_we: 1'b1, ifact_we: 1'b0, addr: '0, data: R_W'(1)};
    end else begin
      mul_v_r       <= mul_go;
      wr_r.fact_we  <= fact_wr;
      wr_r.ifact_we <= ifact_wr;
      unique case (phase_r)
        PH_FACT: begin
          if (!busy_r) begin
            mul_a_r <= acc_r;
            mul_b_r <= R_W'(idx_r);
            busy_r  <= 1'b1;
          end else if (res_v) begin
            busy_r    <= 1'b0;
            wr_r.addr <= idx_r;
            wr_r.data <= res;
            if (idx_r == LAST) begin
              phase_r   <= PH_POW;
              base_r    <= res;
              acc_r     <= R_W'(1);
              bit_r     <= 5'd29;
              sq_done_r <= 1'b0;
            end else begin
              acc_r <= res;
              idx_r <= idx_r + N_W'(1);
            end
          end
        end
        PH_POW: begin
          if (!busy_r) begin
            mul_a_r <= acc_r;
            mul_b_r <= sq_done_r ? base_r : acc_r;
            busy_r  <= 1'b1;
          end else if (res_v) begin
            busy_r <= 1'b0;
            acc_r  <= res;
            if (!sq_done_r && FERMAT_EXP[bit_r]) begin
              sq_done_r <= 1'b1;
            end else begin
              sq_done_r <= 1'b0;
              if (bit_r == 5'd0) begin
                phase_r   <= PH_IFACT;
                idx_r     <= LAST;
                wr_r.addr <= LAST;
                wr_r.data <= res;
              end else begin
                bit_r <= bit_r - 5'd1;
              end
            end
          end
        end
        PH_IFACT: begin
          if (!busy_r) begin
            if (idx_r == '0) begin
              phase_r <= PH_DONE;
            end else begin
              mul_a_r <= acc_r;
              mul_b_r <= R_W'(idx_r);
              busy_r  <= 1'b1;
            end
          end else if (res_v) begin
            busy_r    <= 1'b0;
            acc_r     <= res;
            wr_r.addr <= idx_r - N_W'(1);
            wr_r.data <= res;
            idx_r     <= idx_r - N_W'(1);
          end
        end
        PH_DONE: begin
        end
        default: begin
          phase_r <= PH_DONE;
        end
      endcase
    end
  end

  assign wr   = wr_r;
  assign done = (phase_r == PH_DONE);

endmodule

>>> rtl/binomial_mod_prime_unit.sv
`timescale 1ns / 1ps
// binomial_mod_prime_unit: C(n,k) mod 1000000007 from factorial tables
// depends on bmp_pkg, bmp_query_if, bmp_result_if, bmp_modmul, bmp_init
//
// usage:
//   in_ch carries one query (n_value, k_value) per transaction, out_ch one
//   result binom_mod per query, in query order. k > n or n > TABLE_LIMIT
//   gives zero.
//   after reset the unit fills its factorial and inverse factorial tables;
//   in_ch.ready stays low until the fill is done, as one shared multiplier
//   computes the table entries one after another.
//   afterwards one query is taken per cycle while the skid entry is empty;
//   a result passes the address stage, table read, two four-stage modular
//   multipliers and the output register.
//   an output register with one spare skid entry follows the pipeline: a
//   stalled receiver lets the pipeline keep moving until the skid entry
//   fills, then the whole pipeline and in_ch.ready hold with nothing lost
//   or repeated.
module binomial_mod_prime_unit import bmp_pkg::*; #(
  parameter int unsigned TABLE_LIMIT = 1023
) (
  input logic          clk,
  input logic          rst_n,
  bmp_query_if.sink    in_ch,
  bmp_result_if.source out_ch
);

  localparam int unsigned LIM   = (TABLE_LIMIT < N_MAX) ? TABLE_LIMIT : N_MAX;
  localparam int unsigned DEPTH = LIM + 1;
  localparam int          AW    = $clog2(DEPTH);
  localparam int          ZL    = 2 * MUL_LAT;

  bmp_wr_t        wr;
  logic           init_done;
  logic           en;

  logic [R_W-1:0] fact_mem  [DEPTH];
  logic [R_W-1:0] ifact_mem [DEPTH];

  logic           a_v_r;
  logic           a_z_r;
  logic [AW-1:0]  a_n_r;
  logic [AW-1:0]  a_k_r;
  logic [AW-1:0]  a_d_r;
  logic           b_v_r;
  logic           b_z_r;
  logic [R_W-1:0] b_fact_r;
  logic [R_W-1:0] b_ik_r;
  logic [R_W-1:0] b_id_r;
  logic [R_W-1:0] fact_dl_r [MUL_LAT];
  logic           z_dl_r    [ZL];

  logic           m1_v;
  logic [R_W-1:0] m1_res;
  logic           m2_v;
  logic [R_W-1:0] m2_res;
  logic [R_W-1:0] p_d;

  logic           o_v_r;
  logic [R_W-1:0] o_d_r;
  logic           s_v_r;
  logic [R_W-1:0] s_d_r;

  logic           q_zero;
  logic [N_W-1:0] q_diff;

  bmp_init #(.LIM(LIM)) u_init (
    .clk  (clk),
    .rst_n(rst_n),
    .wr   (wr),
    .done (init_done)
  );

  assign en          = !s_v_r;
  assign in_ch.ready = init_done && en;

  assign q_zero = (in_ch.n_value > N_W'(LIM)) || (in_ch.k_value > in_ch.n_value);
  assign q_diff = in_ch.n_value - in_ch.k_value;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
    end else if (en) begin
      a_v_r <= in_ch.valid && init_done;
      b_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_z_r <= q_zero;
      a_n_r <= in_ch.n_value[AW-1:0];
      a_k_r <= in_ch.k_value[AW-1:0];
      a_d_r <= q_diff[AW-1:0];
      b_z_r <= a_z_r;
    end
  end

  // tables: written by the fill sequencer, read by the query pipeline
  always_ff @(posedge clk) begin
    if (wr.fact_we) begin
      fact_mem[wr.addr[AW-1:0]] <= wr.data;
    end
    if (wr.ifact_we) begin
      ifact_mem[wr.addr[AW-1:0]] <= wr.data;
    end
    if (en) begin
      b_fact_r <= fact_mem[a_n_r];
      b_ik_r   <= ifact_mem[a_k_r];
      b_id_r   <= ifact_mem[a_d_r];
    end
  end

  bmp_modmul u_mul_inner (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (b_v_r),
    .a        (b_ik_r),
    .b        (b_id_r),
    .out_valid(m1_v),
    .result   (m1_res)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      fact_dl_r[0] <= b_fact_r;
      for (int i = 1; i < MUL_LAT; i++) begin
        fact_dl_r[i] <= fact_dl_r[i-1];
      end
      z_dl_r[0] <= b_z_r;
      for (int i = 1; i < ZL; i++) begin
        z_dl_r[i] <= z_dl_r[i-1];
      end
    end
  end

  bmp_modmul u_mul_outer (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (m1_v),
    .a        (fact_dl_r[MUL_LAT-1]),
    .b        (m1_res),
    .out_valid(m2_v),
    .result   (m2_res)
  );

  assign p_d = z_dl_r[ZL-1] ? '0 : m2_res;

  // output register plus one skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_v_r <= 1'b0;
      s_v_r <= 1'b0;
    end else begin
      if (s_v_r) begin
        if (out_ch.ready) begin
          o_d_r <= s_d_r;
          s_v_r <= 1'b0;
        end
      end else if (!o_v_r || out_ch.ready) begin
        o_v_r <= m2_v;
        o_d_r <= p_d;
      end else if (m2_v) begin
        s_v_r <= 1'b1;
        s_d_r <= p_d;
      end
    end
  end

  assign out_ch.valid     = o_v_r;
  assign out_ch.binom_mod = o_d_r;

`ifndef SYNTHESIS
  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    s_v_r |-> o_v_r)
    else $error("skid entry holds a result while the output register is empty");

  a_init_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    $past(init_done) |-> init_done)
    else $error("table fill restarted without reset");

  a_no_query_during_fill: assert property (@(posedge clk) disable iff (!rst_n)
    !init_done |-> !a_v_r && !b_v_r && !m1_v && !m2_v)
    else $error("query in flight while tables are being filled");
`endif

endmodule
